[rtl/mri_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mri_pkg
// Shared sizes, trained Q4.12 constants and the ReLU/rescale helper for the
// 2-3-1 perceptron forward pass.
// ----------------------------------------------------------------------------
package mri_pkg;

  localparam int DataWidth   = 16;  // features (signed Q8.8); hidden values use ValWidth
  localparam int FracBits    = 8;
  localparam int HiddenNodes = 3;
  localparam int WtWidth     = 16;  // Q4.12 weights and biases
  localparam int WFrac       = 12;
  localparam int AccWidth    = 32;
  localparam int ValWidth    = DataWidth - 1;  // non-negative after ReLU

  localparam logic [ValWidth-1:0] MaxVal = {ValWidth{1'b1}};

  typedef logic signed [WtWidth-1:0]  wt_t;
  typedef logic signed [AccWidth-1:0] acc_t;
  typedef logic [ValWidth-1:0]        val_t;

  // Hidden layer weights; nodes past the third carry zeros.
  function automatic wt_t wt_a(input int idx);
    case (idx)
      0:       wt_a = 16'sd2977;
      1:       wt_a = 16'sd5524;
      2:       wt_a = -16'sd3260;
      default: wt_a = '0;
    endcase
  endfunction

  function automatic wt_t wt_b(input int idx);
    case (idx)
      0:       wt_b = -16'sd132;
      1:       wt_b = -16'sd5942;
      2:       wt_b = 16'sd5135;
      default: wt_b = '0;
    endcase
  endfunction

  function automatic wt_t bias_h(input int idx);
    case (idx)
      0:       bias_h = -16'sd3680;
      1:       bias_h = 16'sd2476;
      2:       bias_h = -16'sd1982;
      default: bias_h = '0;
    endcase
  endfunction

  function automatic wt_t wt_o(input int idx);
    case (idx)
      0:       wt_o = -16'sd2357;
      1:       wt_o = 16'sd2618;
      2:       wt_o = 16'sd7059;
      default: wt_o = '0;
    endcase
  endfunction

  localparam wt_t BiasOut = -16'sd1297;

  // Bias moved to the product format: times 2^FracBits, sign extended.
  function automatic acc_t align_bias(input wt_t b);
    align_bias = {{(AccWidth-WtWidth-FracBits){b[WtWidth-1]}}, b, {FracBits{1'b0}}};
  endfunction

  // ReLU, round half up by WFrac bits, clamp to the positive data range.
  function automatic val_t relu_rescale(input acc_t acc);
    logic [AccWidth:0] rnd;
    logic [AccWidth:0] shr;
    rnd = {1'b0, acc} + (AccWidth+1)'(1 << (WFrac - 1));
    shr = rnd >> WFrac;
    if (acc[AccWidth-1] || (acc == '0)) begin
      relu_rescale = '0;
    end else if (shr > {{(AccWidth+1-ValWidth){1'b0}}, MaxVal}) begin
      relu_rescale = MaxVal;
    end else begin
      relu_rescale = shr[ValWidth-1:0];
    end
  endfunction

endpackage
`default_nettype wire

[rtl/mlp_relu_inference_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one beat per cycle; the six-stage multiply/add/ReLU pipeline
//   moves as a unit and only halts when the output register holds a beat
//   that is stalled.
// Reset: rst_ni clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// mlp_relu_inference_core
// Fixed-weight 2-3-1 perceptron, ReLU on hidden and output nodes, Q8.8 data.
// ----------------------------------------------------------------------------
module mlp_relu_inference_core (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       in_valid_i,
  output logic                                      in_stall_o,
  input  wire  logic signed [mri_pkg::DataWidth-1:0] feature_a_i,
  input  wire  logic signed [mri_pkg::DataWidth-1:0] feature_b_i,
  output logic                                      out_valid_o,
  input  wire                                       out_stall_i,
  output logic [mri_pkg::ValWidth-1:0]              score_o
);
  import mri_pkg::*;

  // Whole pipeline advances together. The last stage is the output
  // register; while it holds a stalled beat everything upstream holds too,
  // so no beat is dropped or repeated. Bubbles are not squeezed out.
  logic pipe_en;
  logic hid_valid;
  val_t hidden [HiddenNodes];

  assign pipe_en    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !pipe_en;

  // Stages 1-3: hidden layer
  mri_hidden_layer u_hidden (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .valid_i     (in_valid_i),
    .feature_a_i (feature_a_i),
    .feature_b_i (feature_b_i),
    .valid_o     (hid_valid),
    .hidden_o    (hidden)
  );

  // Stages 4-6: output neuron, final stage is the output register
  mri_output_node u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .valid_i  (hid_valid),
    .hidden_i (hidden),
    .valid_o  (out_valid_o),
    .score_o  (score_o)
  );

endmodule
`default_nettype wire

[rtl/mri_hidden_layer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mri_hidden_layer
// Three stages: products, sum with bias, ReLU and rescale per hidden node.
// ----------------------------------------------------------------------------
module mri_hidden_layer (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       en_i,
  input  wire                                       valid_i,
  input  wire  logic signed [mri_pkg::DataWidth-1:0] feature_a_i,
  input  wire  logic signed [mri_pkg::DataWidth-1:0] feature_b_i,
  output logic                                      valid_o,
  output mri_pkg::val_t                             hidden_o [mri_pkg::HiddenNodes]
);
  import mri_pkg::*;

  acc_t prod_a_q [HiddenNodes];
  acc_t prod_b_q [HiddenNodes];
  acc_t sum_q    [HiddenNodes];
  val_t hid_q    [HiddenNodes];
  logic [2:0] vld_q;

  // stage 1: weight products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < HiddenNodes; i++) begin
        prod_a_q[i] <= AccWidth'(feature_a_i * wt_a(i));
        prod_b_q[i] <= AccWidth'(feature_b_i * wt_b(i));
      end
    end
  end

  // stage 2: sum plus aligned bias; stage 3: ReLU/rescale
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < HiddenNodes; i++) begin
        sum_q[i] <= prod_a_q[i] + prod_b_q[i] + align_bias(bias_h(i));
        hid_q[i] <= relu_rescale(sum_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o  = vld_q[2];
  assign hidden_o = hid_q;

endmodule
`default_nettype wire

[rtl/mri_output_node.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mri_output_node
// Three stages: hidden x output weights, sum with bias, ReLU and rescale.
// ----------------------------------------------------------------------------
module mri_output_node (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  en_i,
  input  wire                  valid_i,
  input  wire  mri_pkg::val_t  hidden_i [mri_pkg::HiddenNodes],
  output logic                 valid_o,
  output mri_pkg::val_t        score_o
);
  import mri_pkg::*;

  acc_t prod_q [HiddenNodes];
  acc_t sum_d;
  acc_t sum_q;
  val_t score_q;
  logic [2:0] vld_q;

  // stage 4: products (hidden value is non-negative, zero extended)
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < HiddenNodes; i++) begin
        prod_q[i] <= AccWidth'($signed({1'b0, hidden_i[i]}) * wt_o(i));
      end
    end
  end

  always_comb begin
    sum_d = align_bias(BiasOut);
    for (int i = 0; i < HiddenNodes; i++) begin
      sum_d = sum_d + prod_q[i];
    end
  end

  // stage 5: sum; stage 6: ReLU/rescale into the output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q   <= sum_d;
      score_q <= relu_rescale(sum_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o = vld_q[2];
  assign score_o = score_q;

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives feature pairs into the 2-3-1 ReLU perceptron core under random
// valid/stall gaps and checks every score beat against a typed-in score or a fixed-point model.
// ----------------------------------------------------------------------------
module testbench;

  import mri_pkg::val_t;
  import mri_pkg::DataWidth;

  typedef logic signed [DataWidth-1:0] feat_t;

  // Trained Q4.12 constants, hidden node n uses WtAn, WtBn, BiasHn, WtOn.
  localparam int WtA0   = 2977;
  localparam int WtA1   = 5524;
  localparam int WtA2   = -3260;
  localparam int WtB0   = -132;
  localparam int WtB1   = -5942;
  localparam int WtB2   = 5135;
  localparam int BiasH0 = -3680;
  localparam int BiasH1 = 2476;
  localparam int BiasH2 = -1982;
  localparam int WtO0   = -2357;
  localparam int WtO1   = 2618;
  localparam int WtO2   = 7059;
  localparam int BiasO  = -1297;

  localparam int     WeightFrac = 12;
  localparam int     BiasAlign  = 256;          // 2^FracBits
  localparam longint ScoreMax   = 32767;
  localparam int     NoTyped    = -1;           // row is checked by the model
  localparam int     NumRows    = 18;
  localparam int     PhaseBeats = 600;

  typedef struct {
    feat_t a;
    feat_t b;
    int    score;
  } stim_row_t;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  feat_t feature_a_i = '0;
  feat_t feature_b_i = '0;
  logic  out_stall_i = 1'b0;
  logic  in_stall_o;
  logic  out_valid_o;
  val_t  score_o;

  // Expected score for the beat on the input, typed in or from the model.
  int typed_score = NoTyped;

  int tx_idle_pct = 21;
  int rx_idle_pct = 78;
  int mismatches  = 0;

  val_t      pending_scores[$];
  stim_row_t directed_rows[NumRows];

  mlp_relu_inference_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .feature_a_i(feature_a_i),
    .feature_b_i(feature_b_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .score_o    (score_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the pipeline hangs.
  initial begin
    #3_000_000;
    $display("FAIL mlp_relu_inference_core");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Fixed-point forward pass
  // --------------------------------------------------------------------------

  // ReLU, round half up from Q.20 to Q.8, clamp to the score range.
  function automatic longint relu_round(input longint acc);
    longint r;
    if (acc <= 0) begin
      return 0;
    end
    r = (acc + (longint'(1) << (WeightFrac - 1))) >>> WeightFrac;
    return (r > ScoreMax) ? ScoreMax : r;
  endfunction

  function automatic longint hidden_value(input longint fa, input longint fb,
                                          input int wa, input int wb,
                                          input int bias);
    return relu_round(fa * wa + fb * wb + longint'(bias) * BiasAlign);
  endfunction

  function automatic val_t predict_score(input feat_t fa, input feat_t fb);
    longint fa_l;
    longint fb_l;
    longint acc;
    fa_l = fa;
    fb_l = fb;
    acc  = hidden_value(fa_l, fb_l, WtA0, WtB0, BiasH0) * WtO0
         + hidden_value(fa_l, fb_l, WtA1, WtB1, BiasH1) * WtO1
         + hidden_value(fa_l, fb_l, WtA2, WtB2, BiasH2) * WtO2
         + longint'(BiasO) * BiasAlign;
    return val_t'(relu_round(acc));
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %0t: %s, got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Push on input beats before popping output beats, so ordering within
  // one edge never matters.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (typed_score == NoTyped) begin
          pending_scores.push_back(predict_score(feature_a_i, feature_b_i));
        end else begin
          pending_scores.push_back(val_t'(typed_score));
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_scores.size() == 0) begin
          report_mismatch("score beat with nothing pending", int'(score_o), NoTyped);
        end else begin
          if (score_o !== pending_scores[0]) begin
            report_mismatch("score", int'(score_o), int'(pending_scores[0]));
          end
          void'(pending_scores.pop_front());
        end
      end
    end
  end

  // Receiver back-pressure, rate set per phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Gaps first, then hold the beat until it is taken.
  task automatic send_beat(input feat_t a, input feat_t b, input int score);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    feature_a_i <= a;
    feature_b_i <= b;
    typed_score <= score;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    while (pending_scores.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // Full range saturates often; narrower ranges exercise the linear region.
  function automatic feat_t random_feature();
    case ($urandom_range(2))
      0:       return feat_t'($urandom);
      1:       return feat_t'(int'($urandom_range(2047)) - 1024);
      default: return feat_t'(int'($urandom_range(16383)) - 8192);
    endcase
  endfunction

  initial begin : stimulus
    int phase;
    int n;

    // zero in: only node 1 fires through its bias, score 18
    directed_rows[0]  = '{16'sh0000, 16'sh0000, 18};
    // node 2 alone saturates, output saturates
    directed_rows[1]  = '{16'sh8000, 16'sh7fff, 32767};
    // node 0 dominates with its negative output weight, ReLU gives zero
    directed_rows[2]  = '{16'sh7fff, 16'sd20000, 0};
    directed_rows[3]  = '{16'sh7fff, 16'sh7fff, NoTyped};
    directed_rows[4]  = '{16'sh8000, 16'sh8000, NoTyped};
    directed_rows[5]  = '{16'sh7fff, 16'sh8000, NoTyped};
    directed_rows[6]  = '{16'sh8000, 16'sh0000, NoTyped};
    directed_rows[7]  = '{16'sh0000, 16'sh8000, NoTyped};
    directed_rows[8]  = '{16'sh7fff, 16'sh0000, NoTyped};
    directed_rows[9]  = '{16'sh0000, 16'sh7fff, NoTyped};
    directed_rows[10] = '{16'shffff, 16'shffff, NoTyped};
    directed_rows[11] = '{16'sh0001, 16'sh0001, NoTyped};
    directed_rows[12] = '{16'sh0100, 16'sh0000, NoTyped};
    directed_rows[13] = '{16'sh0000, 16'sh0100, NoTyped};
    directed_rows[14] = '{16'shff00, 16'sh0100, NoTyped};
    directed_rows[15] = '{16'sh0100, 16'shff00, NoTyped};
    directed_rows[16] = '{16'sh5555, 16'shaaaa, NoTyped};
    directed_rows[17] = '{16'shaaaa, 16'sh5555, NoTyped};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < NumRows; n++) begin
      send_beat(directed_rows[n].a, directed_rows[n].b, directed_rows[n].score);
    end

    // let the pipeline run dry before the random part
    in_valid_i  <= 1'b0;
    typed_score <= NoTyped;
    @(posedge clk_i);
    wait_drained();

    // phase 0: busy sender, heavy stall; 1: the reverse; 2: full rate
    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct <= (phase == 0) ? 21 : (phase == 1) ? 78 : 0;
      rx_idle_pct <= (phase == 0) ? 78 : (phase == 1) ? 21 : 0;
      for (n = 0; n < PhaseBeats; n++) begin
        send_beat(random_feature(), random_feature(), NoTyped);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    repeat (12) @(posedge clk_i);
    if (pending_scores.size() != 0) begin
      report_mismatch("scores never delivered", 0, pending_scores.size());
    end

    if (mismatches == 0) begin
      $display("PASS mlp_relu_inference_core");
    end else begin
      $display("FAIL mlp_relu_inference_core");
    end
    $finish;
  end

endmodule
